/* hdl/assert_macros.svh */
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_RUN(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALL(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/aavs_pkg.sv */
// Shared types and constants for the activity argmax variable selector.
// No dependencies.
package aavs_pkg;

    localparam int MAX_VARS      = 1024;
    localparam int ACTIVITY_BITS = 32;

    localparam int VAR_W  = 11;                      // var_index, var_count, selected_var
    localparam int FUNC_W = 2;
    localparam int ADDR_W = $clog2(MAX_VARS);
    localparam int CNT_W  = ADDR_W + 1;              // holds 0..MAX_VARS
    localparam int CMP_W  = (CNT_W > VAR_W) ? CNT_W : VAR_W;
    localparam int MEM_W  = ACTIVITY_BITS + 1;       // {assigned flag, activity}

    typedef enum logic [FUNC_W-1:0] {
        FUNC_BUMP    = 2'd0,
        FUNC_RESTART = 2'd1,
        FUNC_SELECT  = 2'd2,
        FUNC_SET     = 2'd3
    } func_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [MEM_W-1:0]  wdata;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

endpackage

/* hdl/aavs_ram.sv */
// Simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module aavs_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 33
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/aavs_ctrl.sv */
// Sequencer: clearing pass, read-modify-write for bump/set, table walk for
// restart/select, and the result register. Depends on aavs_pkg.
module aavs_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [aavs_pkg::CNT_W-1:0]  n_vars,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  aavs_pkg::func_t             in_func,
    input  logic [aavs_pkg::VAR_W-1:0]  in_index,
    input  logic                        in_value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        out_found,
    output logic [aavs_pkg::VAR_W-1:0]  out_var,
    output aavs_pkg::mem_req_t          mem_req,
    input  logic [aavs_pkg::MEM_W-1:0]  mem_rdata
);
    import aavs_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RMW,
        ST_SCAN,
        ST_RESULT
    } state_t;

    localparam logic [ACTIVITY_BITS-1:0] ACT_MAX = '1;

    state_t                   state_reg, state_next;
    func_t                    op_reg, op_next;
    logic                     ok_reg, ok_next;
    logic                     val_reg, val_next;
    logic [ADDR_W-1:0]        addr_reg, addr_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     pv_reg, pv_next;
    logic [ADDR_W-1:0]        paddr_reg, paddr_next;
    logic                     have_reg, have_next;
    logic [ACTIVITY_BITS-1:0] best_act_reg, best_act_next;
    logic [CNT_W-1:0]         best_idx_reg, best_idx_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     found_reg, found_next;
    logic [VAR_W-1:0]         sel_reg, sel_next;

    logic [CMP_W-1:0]         idx_wide;
    logic [CMP_W-1:0]         idx_m1;
    logic                     idx_ok;
    logic                     rd_flag;
    logic [ACTIVITY_BITS-1:0] rd_act;

    assign idx_wide = CMP_W'(in_index);
    assign idx_m1   = idx_wide - CMP_W'(1);
    assign idx_ok   = (idx_wide != '0) && (idx_wide <= CMP_W'(MAX_VARS));
    assign rd_flag  = mem_rdata[MEM_W-1];
    assign rd_act   = mem_rdata[ACTIVITY_BITS-1:0];

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_found = found_reg;
    assign out_var   = sel_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        ok_next        = ok_reg;
        val_next       = val_reg;
        addr_next      = addr_reg;
        cnt_next       = cnt_reg;
        pv_next        = pv_reg;
        paddr_next     = paddr_reg;
        have_next      = have_reg;
        best_act_next  = best_act_reg;
        best_idx_next  = best_idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        found_next     = found_reg;
        sel_next       = sel_reg;

        mem_req.we    = 1'b0;
        mem_req.waddr = paddr_reg;
        mem_req.wdata = '0;
        mem_req.raddr = cnt_reg[ADDR_W-1:0];

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = cnt_reg[ADDR_W-1:0];
                if (cnt_reg == CNT_W'(MAX_VARS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            ST_IDLE:
            begin
                // read issued on the accept beat so the entry is ready next cycle
                mem_req.raddr = idx_m1[ADDR_W-1:0];
                if (in_valid)
                begin
                    op_next   = in_func;
                    ok_next   = idx_ok;
                    val_next  = in_value;
                    addr_next = idx_m1[ADDR_W-1:0];
                    unique case (in_func)
                        FUNC_BUMP, FUNC_SET:
                        begin
                            state_next = ST_RMW;
                        end
                        FUNC_RESTART, FUNC_SELECT:
                        begin
                            cnt_next      = '0;
                            pv_next       = 1'b0;
                            have_next     = 1'b0;
                            best_act_next = '0;
                            best_idx_next = '0;
                            state_next    = ST_SCAN;
                        end
                    endcase
                end
            end

            ST_RMW:
            begin
                mem_req.waddr = addr_reg;
                if (op_reg == FUNC_SET)
                begin
                    mem_req.wdata = {val_reg, rd_act};
                end
                else
                begin
                    mem_req.wdata = {rd_flag, (rd_act == ACT_MAX) ? rd_act
                                                                  : rd_act + ACTIVITY_BITS'(1)};
                end
                mem_req.we = ok_reg;
                state_next = ST_IDLE;
            end

            ST_SCAN:
            begin
                // issue side
                if (cnt_reg < n_vars)
                begin
                    cnt_next   = cnt_reg + CNT_W'(1);
                    pv_next    = 1'b1;
                    paddr_next = cnt_reg[ADDR_W-1:0];
                end
                else
                begin
                    pv_next = 1'b0;
                end
                // data side, for the read issued on the previous cycle
                if (pv_reg)
                begin
                    if (op_reg == FUNC_RESTART)
                    begin
                        mem_req.we    = 1'b1;
                        mem_req.wdata = {rd_flag, 1'b0, rd_act[ACTIVITY_BITS-1:1]};
                    end
                    else if (!rd_flag && (!have_reg || rd_act > best_act_reg))
                    begin
                        have_next     = 1'b1;
                        best_act_next = rd_act;
                        best_idx_next = CNT_W'(paddr_reg) + CNT_W'(1);
                    end
                end
                if (!(cnt_reg < n_vars) && !pv_reg)
                begin
                    state_next = (op_reg == FUNC_SELECT) ? ST_RESULT : ST_IDLE;
                end
            end

            ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    found_next     = have_reg;
                    sel_next       = have_reg ? VAR_W'(best_idx_reg) : '0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            pv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pv_reg        <= pv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        ok_reg       <= ok_next;
        val_reg      <= val_next;
        addr_reg     <= addr_next;
        paddr_reg    <= paddr_next;
        have_reg     <= have_next;
        best_act_reg <= best_act_next;
        best_idx_reg <= best_idx_next;
        found_reg    <= found_next;
        sel_reg      <= sel_next;
    end

endmodule

/* hdl/activity_argmax_variable_selector_top.sv */
// Top level: var_count register, sequencer and the activity/flag RAM.
// Depends on aavs_pkg, aavs_ctrl, aavs_ram.
// Bump and set: read on the accept beat, write back the next.
// n = var_count clamped to MAX_VARS. Restart and select walk entries 1..n, one entry a cycle;
// select then loads the result register, held off by any out_ready stall, and returns to idle.
// Reset: a clearing pass zeroes every RAM entry with in_ready low; config taken throughout.
module activity_argmax_variable_selector_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [aavs_pkg::VAR_W-1:0]  cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [aavs_pkg::FUNC_W-1:0] func,
    input  logic [aavs_pkg::VAR_W-1:0]  var_index,
    input  logic                        assigned_value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        found,
    output logic [aavs_pkg::VAR_W-1:0]  selected_var
);
    import aavs_pkg::*;

    logic [VAR_W-1:0] var_count_reg;
    logic [CNT_W-1:0] n_vars;
    mem_req_t         mem_req;
    logic [MEM_W-1:0] mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            var_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            var_count_reg <= cfg_data;
        end
    end

    // clamp to table size
    assign n_vars = (CMP_W'(var_count_reg) > CMP_W'(MAX_VARS)) ? CNT_W'(MAX_VARS)
                                                               : CNT_W'(var_count_reg);

    aavs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .n_vars    (n_vars),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_func   (func_t'(func)),
        .in_index  (var_index),
        .in_value  (assigned_value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_found (found),
        .out_var   (selected_var),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    aavs_ram #(
        .DEPTH (MAX_VARS),
        .WIDTH (MEM_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

endmodule

/* hdl/aavs_checker.sv */
// Port-level checks for the selector top, attached by bind.
// Depends on aavs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module aavs_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic                       found,
    input logic [aavs_pkg::VAR_W-1:0] selected_var
);
    import aavs_pkg::*;

    `ASSERT_ALL(a_reset_quiet, clk, !rst_n |-> !out_valid && !in_ready, "active during reset")
    `ASSERT_RUN(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped")
    `ASSERT_RUN(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(found) && $stable(selected_var), "result beat changed while stalled")
    `ASSERT_RUN(a_none_zero, clk, rst_n, out_valid && !found |-> selected_var == '0, "not-found beat with nonzero variable")
    `ASSERT_RUN(a_found_nonzero, clk, rst_n, out_valid && found |-> selected_var != '0, "found beat with variable zero")

endmodule

bind activity_argmax_variable_selector_top aavs_checker u_aavs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .found        (found),
    .selected_var (selected_var)
);

/* dv/tb_activity_argmax_variable_selector_top.sv */
// Testbench for activity_argmax_variable_selector_top: a directed table, then
// phases of random bump/decide/backtrack/restart traffic, all scored against an
// in-bench activity and assigned-flag model. Depends on aavs_pkg and the RTL.
module tb_activity_argmax_variable_selector_top;
    timeunit 1ns;
    timeprecision 1ps;
    import aavs_pkg::*;

    localparam int SETTLE    = MAX_VARS + 16;   // longest walk of a result-less item
    localparam int WD_LIMIT  = 20000;
    localparam int LONG_HOLD = 300;
    localparam int DIR_ROWS  = 27;

    typedef logic [VAR_W-1:0]         var_t;
    typedef logic [ACTIVITY_BITS-1:0] act_t;

    typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t kind;
        func_t     fn;
        var_t      arg;        // var_index, or var_count for a config row
        bit        val;
        bit        typed;      // expected pick given in the row
        bit        exp_found;
        var_t      exp_var;
    } dir_row_t;

    typedef struct {
        bit   found;
        var_t var_id;
    } pick_t;

    logic  clk = 1'b0;
    logic  rst_n;
    logic  cfg_we;
    var_t  cfg_data;
    logic  in_valid;
    logic  in_ready;
    func_t func;
    var_t  var_index;
    logic  assigned_value;
    logic  out_valid;
    logic  out_ready;
    logic  found;
    var_t  selected_var;

    // Model state
    act_t  activity [1:MAX_VARS];
    bit    assigned [1:MAX_VARS];
    var_t  vc_reg;
    pick_t pending_picks [$];

    int errors      = 0;
    int live_items  = 0;
    int hold_reqs   = 0;
    int idle_cycles = 0;
    bit idle_on     = 1'b1;

    dir_row_t dir_tab [DIR_ROWS] = '{
        '{ROW_ITEM, FUNC_SELECT,  11'd0,    1'b0, 1'b1, 1'b0, 11'd0},
        '{ROW_ITEM, FUNC_BUMP,    11'd1,    1'b0, 1'b0, 1'b0, 11'd0},
        '{ROW_ITEM, FUNC_SELECT,  11'd0,    1'b0, 1'b1, 1'b0, 11'd0},
        '{ROW_CFG,  FUNC_BUMP,    11'd4,    1'b0, 1'b0, 1'b0, 11'd0},
        '{ROW_ITEM, FUNC_SELECT,  11'd0,    1'b0, 1'b1, 1'b1, 11'd1},
        '{ROW_ITEM, FUNC_BUMP,    11'd3,    1'b1, 1'b0, 1'b0, 11'd0},
        '{ROW_ITEM, FUNC_BUMP,    11'd3,    1'b0, 1'b0, 1'b0, 11'd0},
        '{ROW_ITEM, FUNC_BUMP,    11'd2,    1'b0, 1'b0, 1'b0, 11'd0},
        '{ROW_ITEM, FUNC_SELECT,  11'd2047, 1'b1, 1'b0, 1'b0, 11'd0},
        '{ROW_ITEM, FUNC_SET,     11'd3,    1'b1, 1'b0, 1'b0, 11'd0},
        '{ROW_ITEM, FUNC_SELECT,  11'd0,    1'b0, 1'b0, 1'b0, 11'd0},
        '{ROW_ITEM, FUNC_BUMP,    11'd0,    1'b0, 1'b0, 1'b0, 11'd0},
        '{ROW_ITEM, FUNC_BUMP,    11'd1025, 1'b0, 1'b0, 1'b0, 11'd0},
        '{ROW_ITEM, FUNC_SET,     11'd2047, 1'b1, 1'b0, 1'b0, 11'd0},
        '{ROW_ITEM, FUNC_SET,     11'd0,    1'b1, 1'b0, 1'b0, 11'd0},
        '{ROW_ITEM, FUNC_BUMP,    11'd1024, 1'b0, 1'b0, 1'b0, 11'd0},
        '{ROW_ITEM, FUNC_SET,     11'd1000, 1'b1, 1'b0, 1'b0, 11'd0},
        '{ROW_ITEM, FUNC_RESTART, 11'd0,    1'b0, 1'b0, 1'b0, 11'd0},
        '{ROW_ITEM, FUNC_SELECT,  11'd0,    1'b0, 1'b0, 1'b0, 11'd0},
        '{ROW_ITEM, FUNC_SET,     11'd1,    1'b1, 1'b0, 1'b0, 11'd0},
        '{ROW_ITEM, FUNC_SET,     11'd2,    1'b1, 1'b0, 1'b0, 11'd0},
        '{ROW_ITEM, FUNC_SET,     11'd4,    1'b1, 1'b0, 1'b0, 11'd0},
        '{ROW_ITEM, FUNC_SELECT,  11'd0,    1'b0, 1'b1, 1'b0, 11'd0},
        '{ROW_CFG,  FUNC_BUMP,    11'd2047, 1'b0, 1'b0, 1'b0, 11'd0},
        '{ROW_ITEM, FUNC_SELECT,  11'd0,    1'b0, 1'b0, 1'b0, 11'd0},
        '{ROW_ITEM, FUNC_RESTART, 11'd0,    1'b0, 1'b0, 1'b0, 11'd0},
        '{ROW_ITEM, FUNC_SELECT,  11'd0,    1'b0, 1'b0, 1'b0, 11'd0}
    };

    activity_argmax_variable_selector_top DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .var_index      (var_index),
        .assigned_value (assigned_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .found          (found),
        .selected_var   (selected_var)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Applies one item to the model; returns 1 when it yields a pick.
    function automatic bit vsids_step(func_t fn, var_t idx, bit val, output pick_t pick);
        int   n;
        bit   have;
        act_t best;
        n    = (vc_reg > MAX_VARS) ? MAX_VARS : int'(vc_reg);
        have = 1'b0;
        best = '0;
        pick = '{1'b0, '0};
        case (fn)
            FUNC_BUMP:
            begin
                // saturation is out of reach in a run this short, kept for fidelity
                if (idx >= 1 && idx <= MAX_VARS)
                begin
                    if (activity[idx] != '1)
                        activity[idx] = activity[idx] + act_t'(1);
                end
                return 1'b0;
            end
            FUNC_RESTART:
            begin
                for (int i = 1; i <= n; i++)
                    activity[i] = activity[i] / 2;
                return 1'b0;
            end
            FUNC_SET:
            begin
                if (idx >= 1 && idx <= MAX_VARS)
                    assigned[idx] = val;
                return 1'b0;
            end
            default:
            begin
                for (int i = 1; i <= n; i++)
                begin
                    if (!assigned[i] && (!have || activity[i] > best))
                    begin
                        have        = 1'b1;
                        best        = activity[i];
                        pick.found  = 1'b1;
                        pick.var_id = var_t'(i);
                    end
                end
                return 1'b1;
            end
        endcase
    endfunction

    function automatic var_t rand_index(int n);
        if (n == 0 || $urandom_range(0, 9) == 0)
            return var_t'($urandom_range(0, 2047));
        return var_t'($urandom_range(1, n));
    endfunction

    // Offers one beat, waits for it to be taken, then updates the model.
    task automatic send_item(func_t fn, var_t idx, bit val, bit typed, pick_t typed_pick,
                             output pick_t pick);
        pick_t p;
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        func           <= fn;
        var_index      <= idx;
        assigned_value <= val;
        do
            @(posedge clk);
        while (!in_ready);
        if (vsids_step(fn, idx, val, p))
            pending_picks.push_back(typed ? typed_pick : p);
        if (!((fn == FUNC_BUMP || fn == FUNC_SET) && (idx == 0 || idx > MAX_VARS)))
            live_items++;
        pick = p;
    endtask

    // Quiet point for config writes: all picks back, then room for a full walk.
    task automatic drain_and_settle();
        in_valid <= 1'b0;
        while (pending_picks.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_cfg(var_t v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        vc_reg    = v;
    endtask

    task automatic run_phase(var_t vc, int n_items, bit with_hold);
        int    n;
        int    start;
        int    k;
        pick_t p;
        pick_t none;
        drain_and_settle();
        write_cfg(vc);
        n     = (vc > MAX_VARS) ? MAX_VARS : int'(vc);
        none  = '{1'b0, '0};
        start = live_items;
        if (with_hold)
            hold_reqs++;
        while (live_items - start < n_items)
        begin
            k = $urandom_range(0, 99);
            if (k < 45)
            begin
                // clause: one bump per literal
                repeat ($urandom_range(1, 5))
                    send_item(FUNC_BUMP, rand_index(n), 1'($urandom_range(0, 1)), 1'b0,
                              none, p);
            end
            else if (k < 65)
            begin
                // decision: pick a variable, then assign it
                send_item(FUNC_SELECT, var_t'($urandom_range(0, 2047)),
                          1'($urandom_range(0, 1)), 1'b0, none, p);
                if (p.found)
                    send_item(FUNC_SET, p.var_id, 1'b1, 1'b0, none, p);
            end
            else if (k < 75)
            begin
                // backtrack: unassign a few
                repeat ($urandom_range(1, 6))
                    send_item(FUNC_SET, rand_index(n), 1'b0, 1'b0, none, p);
            end
            else if (k < 83)
                send_item(FUNC_RESTART, var_t'($urandom_range(0, 2047)),
                          1'($urandom_range(0, 1)), 1'b0, none, p);
            else
                send_item(func_t'($urandom_range(0, 3)), var_t'($urandom_range(0, 2047)),
                          1'($urandom_range(0, 1)), 1'b0, none, p);
        end
    endtask

    initial
    begin : stimulus
        pick_t    p;
        dir_row_t row;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        func           = FUNC_BUMP;
        var_index      = '0;
        assigned_value = 1'b0;
        vc_reg         = '0;
        for (int i = 1; i <= MAX_VARS; i++)
        begin
            activity[i] = '0;
            assigned[i] = 1'b0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[r])
        begin
            row = dir_tab[r];
            if (row.kind == ROW_CFG)
            begin
                drain_and_settle();
                write_cfg(row.arg);
            end
            else
                send_item(row.fn, row.arg, row.val, row.typed, '{row.exp_found, row.exp_var}, p);
        end

        run_phase(11'd1, 60, 1'b0);
        run_phase(11'd0, 40, 1'b0);
        run_phase(11'd5, 250, 1'b1);
        run_phase(11'd2047, 40, 1'b0);
        run_phase(11'd12, 300, 1'b0);
        run_phase(11'd1024, 30, 1'b0);
        run_phase(var_t'($urandom_range(2, 64)), 300, 1'b0);
        run_phase(11'd3, 250, 1'b0);
        idle_on = 1'b0;
        run_phase(var_t'($urandom_range(2, 40)), 380, 1'b0);

        drain_and_settle();
        if (errors == 0 && pending_picks.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Result side: random back-pressure plus one long hold-off on request.
    initial
    begin : result_sink
        int seen;
        seen      = 0;
        out_ready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_reqs != seen)
            begin
                seen = hold_reqs;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
            if (idle_on && $urandom_range(0, 2) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : check_picks
        pick_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_picks.size() == 0)
            begin
                $display("%0t: unexpected result beat: found %0b selected_var %0d",
                         $time, found, selected_var);
                errors++;
            end
            else
            begin
                want = pending_picks.pop_front();
                if (found !== want.found)
                begin
                    $display("%0t: found mismatch: expected %0b, actual %0b",
                             $time, want.found, found);
                    errors++;
                end
                if (selected_var !== want.var_id)
                begin
                    $display("%0t: selected_var mismatch: expected %0d, actual %0d",
                             $time, want.var_id, selected_var);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WD_LIMIT)
        begin
            $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule
